@@ rtl/bfe_pkg.sv @@
// Shared types and constants for the boundary fill engine.
package bfe_pkg;

  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;
  localparam int STACK_DEPTH  = 4096;
  localparam int COLOR_BITS   = 8;

  localparam int COORD_BITS  = 9;                // width of the pos_x / pos_y fields
  localparam int SCOORD_BITS = COORD_BITS + 1;   // neighbor of the last column needs one more
  localparam int FRAME_SIZE  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int FADDR_BITS  = $clog2(FRAME_SIZE);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int SP_BITS     = STACK_AW + 1;
  localparam int STACK_WORD  = 2 * SCOORD_BITS;
  localparam int COUNT_BITS  = 19;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic REG_FILL_COLOR     = 1'b0;
  localparam logic REG_BOUNDARY_COLOR = 1'b1;

  typedef struct packed {
    logic [1:0]            func;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [7:0]            pixel_color;
  } cmd_t;

  typedef struct packed {
    logic [7:0]            read_color;
    logic [COUNT_BITS-1:0] painted_count;
    logic                  status;
  } result_t;

endpackage

@@ rtl/bfe_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/boundary_fill_engine.sv @@
// Frame store of colour indices with a 4-connected boundary fill. After a write item a new
// item may follow at once; a read passes through a read state first. A fill runs pop,
// load and check per popped pixel, a test when that pixel lies inside the frame off row 0
// and column 0, and four pushes when it is painted, and ends on the pop of the empty
// stack; the seed skips pop and load. The frame RAM and the stack RAM each serve one
// access a cycle. busy stays high until the result is posted; done marks the single
// result cycle and the receiver cannot stall. No clearing pass after reset.
module boundary_fill_engine
  import bfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0]             state;
  logic [COLOR_BITS-1:0]  fill_color;
  logic [COLOR_BITS-1:0]  boundary_color;
  logic [SCOORD_BITS-1:0] cur_x;
  logic [SCOORD_BITS-1:0] cur_y;
  logic [SP_BITS-1:0]     sp;
  logic [1:0]             push_idx;
  logic [COUNT_BITS-1:0]  painted;

  logic                   cmd_inside;
  logic                   cur_inside;
  logic [FADDR_BITS-1:0]  cmd_addr;
  logic [FADDR_BITS-1:0]  cur_addr;
  logic                   frame_we;
  logic [FADDR_BITS-1:0]  frame_addr;
  logic [COLOR_BITS-1:0]  frame_wdata;
  logic [COLOR_BITS-1:0]  frame_rdata;
  logic                   paint;
  logic                   stack_we;
  logic [STACK_AW-1:0]    stack_raddr;
  logic [STACK_WORD-1:0]  stack_wdata;
  logic [STACK_WORD-1:0]  stack_rdata;
  logic [SCOORD_BITS-1:0] nb_x;
  logic [SCOORD_BITS-1:0] nb_y;
  logic                   stack_full;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign busy      = (state != S_IDLE);
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BOUNDARY_COLOR) begin
      prdata[COLOR_BITS-1:0] = boundary_color;
    end else begin
      prdata[COLOR_BITS-1:0] = fill_color;
    end
  end

  assign cmd_inside = (32'(cmd.pos_x) < FRAME_WIDTH) && (32'(cmd.pos_y) < FRAME_HEIGHT);
  assign cur_inside = (cur_x != '0) && (cur_y != '0) &&
                      (32'(cur_x) < FRAME_WIDTH) && (32'(cur_y) < FRAME_HEIGHT);
  assign cmd_addr = FADDR_BITS'(32'(cmd.pos_y) * FRAME_WIDTH + 32'(cmd.pos_x));
  assign cur_addr = FADDR_BITS'(32'(cur_y) * FRAME_WIDTH + 32'(cur_x));

  // paint when the pixel holds neither stop colour
  assign paint = (frame_rdata != fill_color) && (frame_rdata != boundary_color);

  always_comb begin
    frame_we    = 1'b0;
    frame_addr  = cur_addr;
    frame_wdata = fill_color;
    if (state == S_IDLE) begin
      frame_addr  = cmd_addr;
      frame_wdata = COLOR_BITS'(cmd.pixel_color);
      frame_we    = start && (cmd.func == FUNC_WRITE) && cmd_inside;
    end else if (state == S_TEST) begin
      frame_we = paint;
    end
  end

  bfe_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (FRAME_SIZE)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_addr),
    .wdata (frame_wdata),
    .raddr (frame_addr),
    .rdata (frame_rdata)
  );

  // neighbor order: right, left, lower, upper
  always_comb begin
    nb_x = cur_x;
    nb_y = cur_y;
    case (push_idx)
      2'd0:    nb_x = cur_x + 1'b1;
      2'd1:    nb_x = cur_x - 1'b1;
      2'd2:    nb_y = cur_y + 1'b1;
      default: nb_y = cur_y - 1'b1;
    endcase
  end

  assign stack_full  = (32'(sp) >= STACK_DEPTH);
  assign stack_we    = (state == S_PUSH) && !stack_full;
  assign stack_wdata = {nb_y, nb_x};
  assign stack_raddr = STACK_AW'(sp - 1'b1);

  bfe_ram #(
    .WIDTH (STACK_WORD),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (sp[STACK_AW-1:0]),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill_color     <= '0;
      boundary_color <= COLOR_BITS'(1);
      sp             <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        if (paddr[2] == REG_BOUNDARY_COLOR) begin
          boundary_color <= pwdata[COLOR_BITS-1:0];
        end else begin
          fill_color <= pwdata[COLOR_BITS-1:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            result <= '0;
            case (cmd.func)
              FUNC_FILL: begin
                // the seed goes straight to the check, as if pushed and popped
                cur_x   <= SCOORD_BITS'(cmd.pos_x);
                cur_y   <= SCOORD_BITS'(cmd.pos_y);
                sp      <= '0;
                painted <= '0;
                state   <= S_CHECK;
              end
              FUNC_READ: begin
                if (cmd_inside) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          result.read_color <= 8'(frame_rdata);
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_POP: begin
          if (sp == '0) begin
            result.painted_count <= painted;
            result.status        <= 1'b0;
            done                 <= 1'b1;
            state                <= S_IDLE;
          end else begin
            sp    <= sp - 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur_x <= stack_rdata[SCOORD_BITS-1:0];
          cur_y <= stack_rdata[STACK_WORD-1:SCOORD_BITS];
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= cur_inside ? S_TEST : S_POP;
        end
        S_TEST: begin
          if (paint) begin
            painted  <= painted + 1'b1;
            push_idx <= 2'd0;
            state    <= S_PUSH;
          end else begin
            state <= S_POP;
          end
        end
        S_PUSH: begin
          if (stack_full) begin
            result.painted_count <= painted;
            result.status        <= 1'b1;
            sp                   <= '0;
            done                 <= 1'b1;
            state                <= S_IDLE;
          end else begin
            sp       <= sp + 1'b1;
            push_idx <= push_idx + 1'b1;
            if (push_idx == 2'd3) begin
              state <= S_POP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
